### design/pcet_pkg.sv
// ----------------------------------------------------------------------------
// pcet_pkg
// shared constants, types and budget helpers for the per-code event throttle
// ----------------------------------------------------------------------------
package pcet_pkg;

  localparam int TABLE_ENTRIES = 63;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int SLOT_W   = 6;
  localparam int TID_W    = 31;
  localparam int TIME_W   = 63;
  localparam int CNT_W    = 32;
  localparam int LIMIT_W  = 31;
  localparam int IVL_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [LIMIT_W-1:0] RESET_LIMIT    = 31'd200;
  localparam logic [IVL_W-1:0]   RESET_INTERVAL = 32'd1000000;
  localparam logic [CNT_W-1:0]   FIRST_MIN      = 32'd24;
  localparam logic [CNT_W-1:0]   FIRST_MAX      = 32'd48;
  localparam logic [CNT_W-1:0]   CNT_FLOOR      = 32'h8000_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'd1;

  // input kinds
  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_SWEEP   = 1'b1;

  // result kinds
  localparam logic [1:0] RES_VERDICT = 2'd0;
  localparam logic [1:0] RES_REPORT  = 2'd1;
  localparam logic [1:0] RES_END     = 2'd2;

  typedef struct packed {
    logic [TID_W-1:0]  owner;
    logic [TIME_W-1:0] claim_time;
    logic [CNT_W-1:0]  owner_budget;
    logic [CNT_W-1:0]  shared_budget;
  } entry_t;

  typedef struct packed {
    logic       in_load;
    logic       rd_en;
    logic       rd_sweep;
    logic       acq_wr;
    logic       sw_wr;
    logic       idx_clr;
    logic       idx_inc;
    logic       out_load;
    logic [1:0] out_kind;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic sw_qual;
    logic sw_report;
  } sts_t;

  function automatic logic [CNT_W-1:0] first_budget(input logic [LIMIT_W-1:0] lim);
    logic [CNT_W-1:0] half;
    half = {2'b00, lim[LIMIT_W-1:1]};
    if (half < FIRST_MIN) return FIRST_MIN;
    else if (half > FIRST_MAX) return FIRST_MAX;
    else return half;
  endfunction

  function automatic logic [CNT_W-1:0] rest_budget(input logic [LIMIT_W-1:0] lim);
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] f;
    total = {1'b0, lim};
    f = first_budget(lim);
    if (total > f) return total - f;
    else return '0;
  endfunction

  function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
    if (v == CNT_FLOOR) return v;
    else return v - CNT_W'(1);
  endfunction

endpackage

### design/pcet_dp.sv
// ----------------------------------------------------------------------------
// pcet_dp
// entry table, config registers, update logic and result register
// ----------------------------------------------------------------------------
module pcet_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pcet_pkg::cmd_t                      cmd,
  output pcet_pkg::sts_t                      sts,
  input  logic                                cfg_we,
  input  logic [pcet_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic [pcet_pkg::SLOT_W-1:0]         in_slot,
  input  logic [pcet_pkg::TID_W-1:0]          in_thread_id,
  input  logic                                in_is_warn,
  input  logic [pcet_pkg::TIME_W-1:0]         in_now_us,
  output logic [1:0]                          out_result_kind,
  output logic                                out_allowed,
  output logic [pcet_pkg::SLOT_W-1:0]         out_report_slot,
  output logic [31:0]                         out_dropped,
  output logic [pcet_pkg::TID_W-1:0]          out_first_thread,
  output logic                                out_last
);

  logic [pcet_pkg::LIMIT_W-1:0] limit_r;
  logic [pcet_pkg::IVL_W-1:0]   interval_r;

  logic [pcet_pkg::TID_W-1:0]   tid_r;
  logic                         warn_r;
  logic [pcet_pkg::TIME_W-1:0]  now_r;
  logic [pcet_pkg::IDX_W-1:0]   idx_r;
  logic [pcet_pkg::IDX_W-1:0]   rd_addr_r;
  logic [pcet_pkg::IDX_W-1:0]   acq_addr;
  logic [pcet_pkg::IDX_W-1:0]   rd_addr;

  pcet_pkg::entry_t mem [pcet_pkg::TABLE_ENTRIES];
  logic [pcet_pkg::TABLE_ENTRIES-1:0] vld_r;
  pcet_pkg::entry_t mem_q_r;
  logic             mem_vld_r;
  pcet_pkg::entry_t ent;
  pcet_pkg::entry_t acq_ent;
  pcet_pkg::entry_t sw_ent;
  pcet_pkg::entry_t wr_data;
  logic             wr_en;

  logic [pcet_pkg::CNT_W-1:0] first_b;
  logic [pcet_pkg::CNT_W-1:0] rest_b;

  logic                       claim;
  logic                       match;
  logic                       use_shared;
  logic                       throttle_on;
  logic                       acq_ok;
  logic                       allowed;
  logic [pcet_pkg::CNT_W-1:0] ob_n;
  logic [pcet_pkg::CNT_W-1:0] sb_n;
  logic signed [63:0]         age;

  logic [1:0]                  res_kind_r,    res_kind_nxt;
  logic                        res_allowed_r, res_allowed_nxt;
  logic [pcet_pkg::SLOT_W-1:0] res_slot_r,    res_slot_nxt;
  logic [31:0]                 res_dropped_r, res_dropped_nxt;
  logic [pcet_pkg::TID_W-1:0]  res_thread_r,  res_thread_nxt;
  logic                        res_last_r,    res_last_nxt;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= pcet_pkg::RESET_LIMIT;
      interval_r <= pcet_pkg::RESET_INTERVAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcet_pkg::REG_LIMIT:    limit_r    <= cfg_data[pcet_pkg::LIMIT_W-1:0];
        pcet_pkg::REG_INTERVAL: interval_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // slot clamp: out of range slots share the last entry
  always_comb begin
    if (in_slot >= pcet_pkg::SLOT_W'(pcet_pkg::TABLE_ENTRIES))
      acq_addr = pcet_pkg::IDX_W'(pcet_pkg::TABLE_ENTRIES - 1);
    else
      acq_addr = in_slot[pcet_pkg::IDX_W-1:0];
  end

  assign rd_addr = cmd.rd_sweep ? idx_r : acq_addr;

  // item latch and sweep index
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      tid_r  <= in_thread_id;
      warn_r <= in_is_warn;
      now_r  <= in_now_us;
    end
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + pcet_pkg::IDX_W'(1);
  end

  // table read port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      mem_q_r   <= mem[rd_addr];
      mem_vld_r <= vld_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // table write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[rd_addr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (wr_en) vld_r[rd_addr_r] <= 1'b1;
  end

  // entry never written reads as its reset contents
  always_comb begin
    if (mem_vld_r) begin
      ent = mem_q_r;
    end else begin
      ent.owner         = '0;
      ent.claim_time    = '0;
      ent.owner_budget  = pcet_pkg::first_budget(pcet_pkg::RESET_LIMIT);
      ent.shared_budget = pcet_pkg::rest_budget(pcet_pkg::RESET_LIMIT);
    end
  end

  assign first_b = pcet_pkg::first_budget(limit_r);
  assign rest_b  = pcet_pkg::rest_budget(limit_r);

  // acquire update
  always_comb begin
    claim       = (ent.owner == '0);
    match       = claim || (ent.owner == tid_r);
    ob_n        = match ? pcet_pkg::dec_sat(ent.owner_budget) : ent.owner_budget;
    use_shared  = match ? ob_n[pcet_pkg::CNT_W-1] : 1'b1;
    sb_n        = use_shared ? pcet_pkg::dec_sat(ent.shared_budget) : ent.shared_budget;
    acq_ok      = !(use_shared && sb_n[pcet_pkg::CNT_W-1]);
    throttle_on = warn_r && (limit_r != '0);
    allowed     = throttle_on ? acq_ok : 1'b1;

    acq_ent.owner         = claim ? tid_r : ent.owner;
    acq_ent.claim_time    = claim ? now_r : ent.claim_time;
    acq_ent.owner_budget  = ob_n;
    acq_ent.shared_budget = sb_n;
  end

  // sweep restore
  always_comb begin
    age = $signed({1'b0, now_r}) - $signed({1'b0, ent.claim_time});
    sw_ent.owner         = '0;
    sw_ent.claim_time    = ent.claim_time;
    sw_ent.owner_budget  = first_b;
    sw_ent.shared_budget = rest_b;
  end

  assign sts.sw_qual   = (ent.owner != '0) && (age > $signed({32'b0, interval_r}));
  assign sts.sw_report = ent.shared_budget[pcet_pkg::CNT_W-1];
  assign sts.idx_last  = (idx_r == pcet_pkg::IDX_W'(pcet_pkg::TABLE_ENTRIES - 1));

  assign wr_en   = (cmd.acq_wr && throttle_on) || cmd.sw_wr;
  assign wr_data = cmd.sw_wr ? sw_ent : acq_ent;

  // result register
  always_comb begin
    res_kind_nxt    = cmd.out_kind;
    res_allowed_nxt = 1'b0;
    res_slot_nxt    = '0;
    res_dropped_nxt = '0;
    res_thread_nxt  = '0;
    res_last_nxt    = 1'b1;
    unique case (cmd.out_kind)
      pcet_pkg::RES_VERDICT: res_allowed_nxt = allowed;
      pcet_pkg::RES_REPORT: begin
        res_slot_nxt    = pcet_pkg::SLOT_W'(rd_addr_r);
        res_dropped_nxt = 32'(32'd0 - ent.shared_budget);
        res_thread_nxt  = ent.owner;
        res_last_nxt    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_kind_r    <= res_kind_nxt;
      res_allowed_r <= res_allowed_nxt;
      res_slot_r    <= res_slot_nxt;
      res_dropped_r <= res_dropped_nxt;
      res_thread_r  <= res_thread_nxt;
      res_last_r    <= res_last_nxt;
    end
  end

  assign out_result_kind  = res_kind_r;
  assign out_allowed      = res_allowed_r;
  assign out_report_slot  = res_slot_r;
  assign out_dropped      = res_dropped_r;
  assign out_first_thread = res_thread_r;
  assign out_last         = res_last_r;

endmodule

### design/pcet_ctrl.sv
// ----------------------------------------------------------------------------
// pcet_ctrl
// sequencer for acquire and sweep items and result valid
// ----------------------------------------------------------------------------
module pcet_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_kind,
  output logic           in_stall,
  input  logic           out_stall,
  output logic           out_valid,
  output pcet_pkg::cmd_t cmd,
  input  pcet_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACQ,
    S_SW_RD,
    S_SW_CHK,
    S_SW_END
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_acc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.in_load = 1'b1;
          if (in_kind == pcet_pkg::KIND_ACQUIRE) begin
            cmd.rd_en = 1'b1;
            state_nxt = S_ACQ;
          end else begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_SW_RD;
          end
        end
      end
      S_ACQ: begin
        if (out_free) begin
          cmd.acq_wr   = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_kind = pcet_pkg::RES_VERDICT;
          state_nxt    = S_IDLE;
        end
      end
      S_SW_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sweep = 1'b1;
        state_nxt    = S_SW_CHK;
      end
      S_SW_CHK: begin
        if (!(sts.sw_qual && sts.sw_report) || out_free) begin
          if (sts.sw_qual) cmd.sw_wr = 1'b1;
          if (sts.sw_qual && sts.sw_report) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = pcet_pkg::RES_REPORT;
          end
          if (sts.idx_last) begin
            state_nxt = S_SW_END;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_SW_RD;
          end
        end
      end
      S_SW_END: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = pcet_pkg::RES_END;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // a loaded result is presented next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  // restore writes only happen for aged claimed entries
  a_sweep_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sw_wr |-> (state_r == S_SW_CHK) && sts.sw_qual)
    else $error("sweep write without qualifying entry");

  // an accepted acquire goes straight to its update step
  a_acq_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == pcet_pkg::KIND_ACQUIRE) |=> (state_r == S_ACQ))
    else $error("acquire did not enter update step");

endmodule

### design/per_code_event_throttle_core.sv
// ----------------------------------------------------------------------------
// per_code_event_throttle_core
// per-code throttle table with acquire verdicts and aging sweeps
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall  kind, slot, thread_id, is_warn, now_us
//   out_     out  out_valid/out_stall result_kind, allowed, report_slot,
//                                    dropped, first_thread, last
//   cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// an acquire is one table read, then one read-modify-write
// a sweep reads and checks each table entry in turn after the accepting
// step, then emits the end marker; the table is walked one entry at a time
// reset clears per-entry valid bits at once, no clearing pass
// one item at a time; the next item is taken once the current one has
// handed its last result to the output register
// a stalled output holds the sequencer only when it needs to emit
// ----------------------------------------------------------------------------
module per_code_event_throttle_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [pcet_pkg::SLOT_W-1:0]    in_slot,
  input  logic [pcet_pkg::TID_W-1:0]     in_thread_id,
  input  logic                           in_is_warn,
  input  logic [pcet_pkg::TIME_W-1:0]    in_now_us,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_result_kind,
  output logic                           out_allowed,
  output logic [pcet_pkg::SLOT_W-1:0]    out_report_slot,
  output logic [31:0]                    out_dropped,
  output logic [pcet_pkg::TID_W-1:0]     out_first_thread,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pcet_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  pcet_pkg::cmd_t cmd;
  pcet_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  pcet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  pcet_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_slot          (in_slot),
    .in_thread_id     (in_thread_id),
    .in_is_warn       (in_is_warn),
    .in_now_us        (in_now_us),
    .out_result_kind  (out_result_kind),
    .out_allowed      (out_allowed),
    .out_report_slot  (out_report_slot),
    .out_dropped      (out_dropped),
    .out_first_thread (out_first_thread),
    .out_last         (out_last)
  );

endmodule

### bench/per_code_event_throttle_core_tb.sv
// ----------------------------------------------------------------------------
// per_code_event_throttle_core_tb
// self-checking bench for the per-code event throttle core
//
// keeps its own copy of the throttle table and registers, predicts every
// verdict, drop report and end marker, and checks each output item in order.
// directed items cover reset budgets, the thread zero owner, slot aliasing,
// negative age, register extremes and drop reports. a receiver hold-off fills
// the core, then random traffic runs under three idling patterns.
// ----------------------------------------------------------------------------
module per_code_event_throttle_core_tb;
  import pcet_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int SHARE_MIN     = 24;
  localparam int SHARE_MAX     = 48;
  localparam int BUDGET_FLOOR  = 32'h8000_0000;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [1:0]        kind;
    logic              allowed;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  dropped;
    logic [TID_W-1:0]  thread;
    logic              last;
  } outcome_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic                 in_kind      = KIND_ACQUIRE;
  logic [SLOT_W-1:0]    in_slot      = '0;
  logic [TID_W-1:0]     in_thread_id = '0;
  logic                 in_is_warn   = 1'b0;
  logic [TIME_W-1:0]    in_now_us    = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [1:0]           out_result_kind;
  logic                 out_allowed;
  logic [SLOT_W-1:0]    out_report_slot;
  logic [31:0]          out_dropped;
  logic [TID_W-1:0]     out_first_thread;
  logic                 out_last;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_LIMIT;
  logic [31:0]          cfg_data     = '0;

  // throttle table copy and register copy
  logic [TID_W-1:0]   owner_q  [TABLE_ENTRIES];
  logic [TIME_W-1:0]  claim_q  [TABLE_ENTRIES];
  int                 own_left [TABLE_ENTRIES];
  int                 pool_left[TABLE_ENTRIES];
  logic [LIMIT_W-1:0] limit_reg;
  logic [IVL_W-1:0]   interval_reg;

  outcome_t          expected_outcomes[$];
  int                mismatches     = 0;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                hold_req       = 0;
  int                hold_seen      = 0;
  int                hold_left      = 0;
  logic [TIME_W-1:0] sim_now        = 63'd1000;

  per_code_event_throttle_core u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int owner_share(input logic [LIMIT_W-1:0] lim);
    int half;
    half = int'(lim >> 1);
    if (half < SHARE_MIN) half = SHARE_MIN;
    else if (half > SHARE_MAX) half = SHARE_MAX;
    return half;
  endfunction

  function automatic int pool_share(input logic [LIMIT_W-1:0] lim);
    longint r;
    r = longint'({33'd0, lim}) - longint'(owner_share(lim));
    return (r < 0) ? 0 : int'(r);
  endfunction

  function automatic int spend(input int v);
    return (v == BUDGET_FLOOR) ? v : v - 1;
  endfunction

  function automatic void add_outcome(input logic [1:0] kind, input logic allowed,
                                      input logic [SLOT_W-1:0] slot,
                                      input logic [CNT_W-1:0] dropped,
                                      input logic [TID_W-1:0] thread, input logic last);
    outcome_t o;
    o.kind    = kind;
    o.allowed = allowed;
    o.slot    = slot;
    o.dropped = dropped;
    o.thread  = thread;
    o.last    = last;
    expected_outcomes.insert(expected_outcomes.size(), o);
  endfunction

  function automatic void acquire_verdict(input logic [SLOT_W-1:0] slot,
                                          input logic [TID_W-1:0] tid, input logic warn,
                                          input logic [TIME_W-1:0] now);
    int               idx;
    logic [TID_W-1:0] own;
    int               tcnt;
    logic             ok;
    ok = 1'b1;
    if (warn && limit_reg != 0) begin
      idx  = (slot < TABLE_ENTRIES) ? int'(slot) : TABLE_ENTRIES - 1;
      own  = owner_q[idx];
      tcnt = -1;
      if (own == 0) begin
        claim_q[idx] = now;
        owner_q[idx] = tid;
        own          = tid;
      end
      if (own == tid) begin
        own_left[idx] = spend(own_left[idx]);
        tcnt          = own_left[idx];
      end
      if (tcnt < 0) begin
        pool_left[idx] = spend(pool_left[idx]);
        if (pool_left[idx] < 0) ok = 1'b0;
      end
    end
    add_outcome(RES_VERDICT, ok, '0, '0, '0, 1'b1);
  endfunction

  function automatic void sweep_outcomes(input logic [TIME_W-1:0] now);
    int               f;
    int               r;
    longint           age;
    int               old_pool;
    logic [63:0]      d;
    logic [TID_W-1:0] own;
    f = owner_share(limit_reg);
    r = pool_share(limit_reg);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      own = owner_q[i];
      if (own != 0) begin
        age = longint'({1'b0, now}) - longint'({1'b0, claim_q[i]});
        if (age > longint'({32'd0, interval_reg})) begin
          old_pool     = pool_left[i];
          own_left[i]  = f;
          pool_left[i] = r;
          owner_q[i]   = '0;
          if (old_pool < 0) begin
            d = 64'(-longint'(old_pool));
            add_outcome(RES_REPORT, 1'b0, SLOT_W'(i), d[31:0], own, 1'b0);
          end
        end
      end
    end
    add_outcome(RES_END, 1'b0, '0, '0, '0, 1'b1);
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("ERROR %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        note_mismatch("item with nothing pending", 64'(out_result_kind), '0);
      end else begin
        want = expected_outcomes.pop_front();
        if (out_result_kind !== want.kind)
          note_mismatch("result_kind", 64'(out_result_kind), 64'(want.kind));
        if (out_allowed !== want.allowed)
          note_mismatch("allowed", 64'(out_allowed), 64'(want.allowed));
        if (out_report_slot !== want.slot)
          note_mismatch("report_slot", 64'(out_report_slot), 64'(want.slot));
        if (out_dropped !== want.dropped)
          note_mismatch("dropped", 64'(out_dropped), 64'(want.dropped));
        if (out_first_thread !== want.thread)
          note_mismatch("first_thread", 64'(out_first_thread), 64'(want.thread));
        if (out_last !== want.last)
          note_mismatch("last", 64'(out_last), 64'(want.last));
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic push_item(input logic kind, input logic [SLOT_W-1:0] slot,
                           input logic [TID_W-1:0] tid, input logic warn,
                           input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_slot      <= slot;
    in_thread_id <= tid;
    in_is_warn   <= warn;
    in_now_us    <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == KIND_SWEEP) sweep_outcomes(now);
    else acquire_verdict(slot, tid, warn, now);
  endtask

  task automatic acquire(input logic [SLOT_W-1:0] slot, input logic [TID_W-1:0] tid,
                         input logic warn, input logic [TIME_W-1:0] now);
    push_item(KIND_ACQUIRE, slot, tid, warn, now);
  endtask

  task automatic sweep(input logic [TIME_W-1:0] now);
    push_item(KIND_SWEEP, '0, '0, 1'b0, now);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] limit_data, input logic [31:0] ivl_data);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_index <= REG_LIMIT;
    cfg_data  <= limit_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_reg = limit_data[LIMIT_W-1:0];
    cfg_index <= REG_INTERVAL;
    cfg_data  <= ivl_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    interval_reg = ivl_data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // reset budgets, thread zero, last-slot aliasing, negative age
  task automatic test_reset_budgets();
    acquire(6'd0, 31'd1, 1'b0, 63'd0);
    acquire(6'd63, {TID_W{1'b1}}, 1'b1, TIME_MAX);
    acquire(6'd62, 31'd5, 1'b1, 63'd10);
    acquire(6'd0, 31'd0, 1'b1, 63'd20);
    acquire(6'd0, 31'd9, 1'b1, 63'd30);
    sweep(63'd0);
    sweep(63'd2_000_000);
  endtask

  // register extremes: widest limit and interval, then throttling off
  task automatic test_register_extremes();
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    acquire(6'd3, 31'd3, 1'b1, 63'd0);
    sweep(63'h1_0000_0000);
    sweep(TIME_MAX);
    set_regs(32'd0, 32'd1);
    acquire(6'd4, 31'd4, 1'b1, 63'd5);
    sweep(63'd7);
  endtask

  // non-owners overdraw the shared budget, sweep reports the drops
  task automatic test_drop_reports();
    set_regs(32'd1, 32'd1);
    acquire(6'd1, 31'd11, 1'b1, 63'd100);
    acquire(6'd2, 31'd21, 1'b1, 63'd100);
    sweep(63'd102);
    acquire(6'd1, 31'd11, 1'b1, 63'd103);
    acquire(6'd1, 31'd12, 1'b1, 63'd103);
    acquire(6'd1, 31'd13, 1'b1, 63'd103);
    acquire(6'd2, 31'd21, 1'b1, 63'd103);
    acquire(6'd2, 31'd22, 1'b1, 63'd103);
    sweep(63'd103);
    sweep(63'd105);
  endtask

  // receiver holds off while items keep coming, then the sender drains
  task automatic test_backpressure();
    set_regs(32'd3, 32'd20);
    hold_req++;
    for (int k = 0; k < 24; k++)
      acquire(SLOT_W'(k % 4), TID_W'(1 + k % 3), 1'b1, sim_now + 63'(k));
    quiesce();
    sim_now = sim_now + 63'd40;
    sweep(sim_now);
    for (int k = 0; k < 5; k++)
      acquire(SLOT_W'(k), TID_W'(7), 1'b1, sim_now);
  endtask

  task automatic test_random_traffic(input logic [31:0] lim, input logic [31:0] ivl,
                                     input int count);
    int               pick;
    logic [63:0]      r64;
    logic [31:0]      r32;
    logic [TID_W-1:0] tid;
    set_regs(lim, ivl);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        sim_now = sim_now + 63'($urandom_range(1, 40));
        sweep(sim_now);
      end else if (pick < 80) begin
        sim_now = sim_now + 63'($urandom_range(0, 8));
        acquire(SLOT_W'($urandom_range(0, 7)), TID_W'($urandom_range(1, 4)), 1'b1, sim_now);
      end else begin
        r64 = {$urandom(), $urandom()};
        r32 = $urandom();
        tid = ($urandom_range(9) == 0) ? '0 : r32[TID_W-1:0];
        push_item(r32[31], SLOT_W'($urandom_range(0, 63)), tid,
                  1'($urandom_range(1)), r64[TIME_W-1:0]);
      end
    end
  endtask

  initial begin
    limit_reg    = RESET_LIMIT;
    interval_reg = RESET_INTERVAL;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      owner_q[i]   = '0;
      claim_q[i]   = '0;
      own_left[i]  = owner_share(RESET_LIMIT);
      pool_left[i] = pool_share(RESET_LIMIT);
    end
    set_idling(26, 80);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_budgets();
    test_register_extremes();
    test_drop_reports();
    test_backpressure();
    test_random_traffic(32'd1, 32'd30, 110);
    set_idling(80, 26);
    test_random_traffic(32'd100, 32'd200, 110);
    set_idling(0, 0);
    test_random_traffic(32'($urandom_range(0, 80)), 32'($urandom_range(1, 100)), 110);

    quiesce();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
design/pcet_pkg.sv
design/pcet_dp.sv
design/pcet_ctrl.sv
design/per_code_event_throttle_core.sv
bench/per_code_event_throttle_core_tb.sv
